[hw/rtl/fscl_pkg.sv]
// Package for the FP16 sine/cosine lookup block.
// Holds the shared constants, the pipeline control struct and the quarter-wave ROM contents.
// Depends on nothing; every other file but the checker uses it by scoped names.
package fscl_pkg;

    // Table geometry: one quadrant of 64 steps, 65 entries including both ends.
    localparam int TABLE_STEPS = 64;
    localparam int ROM_DEPTH   = TABLE_STEPS + 1;
    localparam int POS_W       = $clog2(ROM_DEPTH);

    // FP16 layout and decode constants.
    localparam int         HALF_W    = 16;
    localparam int         MANT_W    = 10;
    localparam int         EXP_W     = 5;
    localparam logic [4:0] EXP_BIAS  = 5'd15;
    localparam logic [4:0] EXP_MIN   = 5'd5;    // exponents below -10 read as zero
    localparam int         FIXED_W   = 18;      // low product bits that reach the index
    localparam int         IDX_W     = 8;
    localparam logic [5:0] TURN_MULT = 6'd41;   // 2*pi maps to about 256 index steps
    localparam logic [15:0] SIGN_FLIP = 16'h8000;

    // Quadrant codes of the folded index.
    localparam logic [1:0] QUAD_RISE  = 2'd0;
    localparam logic [1:0] QUAD_FALL  = 2'd1;
    localparam logic [1:0] QUAD_NRISE = 2'd2;
    localparam logic [1:0] QUAD_NFALL = 2'd3;

    // Pipe advance enables handed from the top level to the stage modules.
    typedef struct packed {
        logic adv1;
        logic adv2;
        logic adv3;
    } pipe_ctl_t;

    typedef logic [HALF_W-1:0] rom_t [0:ROM_DEPTH-1];

    // pi in unsigned Q60.
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // Unsigned Q60 product, truncated to Q60.
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // sin(i*pi/128) in Q60 from a fixed-point Taylor series.
    function automatic logic [63:0] sine_q60(input int i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] prod;
        x    = (PI_Q60 >> 7) * 64'(i);
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int k = 1; k <= 14; k++)
        begin
            prod = mul_q60(term, x2);
            case (k)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                6:       term = prod / 64'd156;
                7:       term = prod / 64'd210;
                8:       term = prod / 64'd272;
                9:       term = prod / 64'd342;
                10:      term = prod / 64'd420;
                11:      term = prod / 64'd506;
                12:      term = prod / 64'd600;
                13:      term = prod / 64'd702;
                default: term = prod / 64'd812;
            endcase
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    // Non-negative Q60 value below two to FP16, round to nearest even.
    function automatic logic [15:0] q60_to_half(input logic [63:0] v);
        int          p;
        int          shift;
        int          biased;
        logic [63:0] m;
        logic [63:0] rem;
        logic [63:0] half;
        p = 0;
        if (v == 64'd0)
            return 16'd0;
        for (int b = 0; b < 64; b++)
        begin
            if (v[b])
                p = b;
        end
        biased = p - 60 + 15;
        shift  = p - 10;
        m      = v >> shift;
        rem    = v & ((64'd1 << shift) - 64'd1);
        half   = 64'd1 << (shift - 1);
        if (rem > half || (rem == half && m[0]))
            m = m + 64'd1;
        if (m == 64'd2048)
        begin
            m      = 64'd1024;
            biased = biased + 1;
        end
        return {1'b0, biased[4:0], m[9:0]};
    endfunction

    function automatic rom_t build_rom();
        rom_t t;
        for (int i = 0; i < ROM_DEPTH; i++)
            t[i] = q60_to_half(sine_q60(i));
        return t;
    endfunction

    // Quarter-wave FP16 sine constants, entry i = sin(i*pi/128).
    localparam rom_t SINE_ROM = build_rom();

endpackage

[hw/rtl/fscl_index.sv]
// Front half of the pipe: FP16 decode, exponent shift, scale to a turn index.
// Two register stages; uses fscl_pkg.
module fscl_index
(
    input  logic                      clk,
    input  fscl_pkg::pipe_ctl_t       ctl,
    input  logic [15:0]               angle,
    input  logic                      kind,
    output logic [fscl_pkg::IDX_W-1:0] idx
);

    logic [fscl_pkg::FIXED_W-1:0] fixed_reg;
    logic [fscl_pkg::FIXED_W-1:0] fixed_next;
    logic                         neg_reg;
    logic                         kind1_reg;
    logic [fscl_pkg::IDX_W-1:0]   idx_reg;
    logic [fscl_pkg::IDX_W-1:0]   idx_next;

    logic [4:0]  expo;
    logic [4:0]  lsh;
    logic [4:0]  rsh;
    logic [fscl_pkg::FIXED_W-1:0] mant_ext;
    logic [23:0] prod;
    logic [fscl_pkg::IDX_W-1:0]   raw;
    logic [fscl_pkg::IDX_W-1:0]   refl;

    // Stage 1: magnitude with hidden bit, shifted by the unbiased exponent.
    always_comb
    begin
        expo     = angle[14:10];
        lsh      = expo - fscl_pkg::EXP_BIAS;
        rsh      = fscl_pkg::EXP_BIAS - expo;
        mant_ext = {{(fscl_pkg::FIXED_W - 11){1'b0}}, 1'b1, angle[9:0]};
        if (angle[14:0] == 15'd0 || expo < fscl_pkg::EXP_MIN)
            fixed_next = '0;
        else if (expo >= fscl_pkg::EXP_BIAS)
            fixed_next = mant_ext << lsh;
        else
            fixed_next = mant_ext >> rsh;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv1)
        begin
            fixed_reg <= fixed_next;
            neg_reg   <= angle[15];
            kind1_reg <= kind;
        end
    end

    // Stage 2: scale by 41/1024, reflect negatives, add a quarter turn for cosine.
    always_comb
    begin
        prod = {6'd0, fixed_reg} * {18'd0, fscl_pkg::TURN_MULT};
        raw  = prod[17:10];
        refl = neg_reg ? (~raw + 8'd1) : raw;
        idx_next = kind1_reg ? refl + 8'(fscl_pkg::TABLE_STEPS) : refl;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv2)
            idx_reg <= idx_next;
    end

    assign idx = idx_reg;

endmodule

[hw/rtl/fscl_fold.sv]
// Back stage of the pipe: quadrant fold, quarter-wave ROM read and sign flip.
// One register stage that feeds the output; uses fscl_pkg.
module fscl_fold
(
    input  logic                       clk,
    input  fscl_pkg::pipe_ctl_t        ctl,
    input  logic [fscl_pkg::IDX_W-1:0] idx,
    output logic [15:0]                result
);

    logic [15:0] result_reg;
    logic [15:0] result_next;
    logic [fscl_pkg::IDX_W-1:0] pos_full;
    logic [fscl_pkg::POS_W-1:0] pos;
    logic [15:0] flip;

    // Fold the turn index into the first quadrant.
    always_comb
    begin
        case (idx[7:6])
            fscl_pkg::QUAD_RISE:
            begin
                pos_full = idx;
                flip     = 16'd0;
            end
            fscl_pkg::QUAD_FALL:
            begin
                pos_full = 8'(2 * fscl_pkg::TABLE_STEPS) - idx;
                flip     = 16'd0;
            end
            fscl_pkg::QUAD_NRISE:
            begin
                pos_full = idx - 8'(2 * fscl_pkg::TABLE_STEPS);
                flip     = fscl_pkg::SIGN_FLIP;
            end
            default:
            begin
                pos_full = 8'd0 - idx;
                flip     = fscl_pkg::SIGN_FLIP;
            end
        endcase
        if (pos_full > 8'(fscl_pkg::TABLE_STEPS))
            pos = fscl_pkg::POS_W'(fscl_pkg::TABLE_STEPS);
        else
            pos = pos_full[fscl_pkg::POS_W-1:0];
        result_next = fscl_pkg::SINE_ROM[pos] ^ flip;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv3)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

[hw/rtl/fp16_sine_cosine_lookup_top.sv]
// FP16 sine/cosine by quarter-wave table lookup, three-stage pipeline.
// An accepted input beat passes through stage 1, stage 2 and the output register; stalls can hold it.
// Throughput: one beat per cycle while out_stall is low; stages advance into empty slots, so bubbles collapse.
// The third stage is the output register; the ROM is constant logic read in that stage.
// Reset (rst_n low, asynchronous) clears all stage valid bits; payload is not reset.
// Uses fscl_pkg, fscl_index and fscl_fold.
module fp16_sine_cosine_lookup_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] angle,
    input  logic        kind,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] result
);

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    fscl_pkg::pipe_ctl_t ctl;
    logic [fscl_pkg::IDX_W-1:0] idx;

    // Each stage loads when its successor is empty or moving on.
    always_comb
    begin
        ctl.adv3 = !v3_reg || !out_stall;
        ctl.adv2 = !v2_reg || ctl.adv3;
        ctl.adv1 = !v1_reg || ctl.adv2;
    end

    assign in_stall  = !ctl.adv1;
    assign out_valid = v3_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ctl.adv1)
                v1_reg <= in_valid;
            if (ctl.adv2)
                v2_reg <= v1_reg;
            if (ctl.adv3)
                v3_reg <= v2_reg;
        end
    end

    fscl_index u_index
    (
        .clk   (clk),
        .ctl   (ctl),
        .angle (angle),
        .kind  (kind),
        .idx   (idx)
    );

    fscl_fold u_fold
    (
        .clk    (clk),
        .ctl    (ctl),
        .idx    (idx),
        .result (result)
    );

endmodule

[hw/rtl/fscl_checker.sv]
// Port-level checker for the FP16 sine/cosine lookup block, bound to the top level.
// Depends only on the top-level ports.
module fscl_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [15:0] angle,
    input logic        kind,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] result
);

    // A stalled output beat stays and keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result))
    else $error("stalled output beat changed");

    // A stalled input beat is held by the sender with its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(angle) && $stable(kind))
    else $error("stalled input beat changed");

    // A sine or cosine never exceeds one in magnitude.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result[14:0] <= 15'h3C00)
    else $error("result magnitude above one");

    // With the output side free, the input side never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

    // Reset empties the pipe.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
    else $error("output valid during reset");

endmodule

bind fp16_sine_cosine_lookup_top fscl_checker u_fscl_checker (.*);

[test/tb.sv]
// Self-checking bench for the FP16 sine/cosine table lookup, top fp16_sine_cosine_lookup_top.
// A scoreboard class predicts each result from its own table and folding logic.
// Depends on fscl_pkg for constants and on the top module of the block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 500;
    localparam int HOLD_CYCLES  = 200;

    // One predicted output beat together with the input that caused it.
    typedef struct {
        logic [15:0] angle;
        logic        kind;
        logic [15:0] result;
    } trig_expect_t;

    // Predicts the block and checks its output beats in order.
    class trig_scoreboard;
        logic [15:0]  sine_rom [fscl_pkg::ROM_DEPTH];
        trig_expect_t waiting [$];
        int           errors;

        function new();
            errors = 0;
            for (int i = 0; i < fscl_pkg::ROM_DEPTH; i++)
                sine_rom[i] = q60_to_fp16(quarter_sine_q60(i));
        endfunction

        // Unsigned Q60 product, truncated back to Q60.
        function logic [63:0] q60_product(logic [63:0] a, logic [63:0] b);
            logic [127:0] full;
            full = {64'd0, a} * {64'd0, b};
            return full[123:60];
        endfunction

        // sin(i*pi/128) in Q60 from a truncated Taylor series.
        function logic [63:0] quarter_sine_q60(int i);
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] term;
            logic [63:0] acc;
            x    = (64'h3243F6A8885A308D / 64'd128) * 64'(i);
            x2   = q60_product(x, x);
            term = x;
            acc  = x;
            for (int k = 1; k <= 14; k++)
            begin
                term = q60_product(term, x2) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            return acc;
        endfunction

        // Non-negative Q60 value below two to FP16, round to nearest even.
        function logic [15:0] q60_to_fp16(logic [63:0] v);
            int          msb;
            int          sh;
            int          biased;
            logic [63:0] mant;
            logic [63:0] rem;
            logic [63:0] half;
            if (v == 64'd0)
                return 16'd0;
            msb = 63;
            while (!v[msb])
                msb--;
            biased = msb - 60 + 15;
            sh     = msb - 10;
            mant   = v >> sh;
            rem    = v & ((64'd1 << sh) - 64'd1);
            half   = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && mant[0]))
                mant = mant + 64'd1;
            if (mant == 64'd2048)
            begin
                mant   = 64'd1024;
                biased = biased + 1;
            end
            return {1'b0, 5'(biased), mant[9:0]};
        endfunction

        // Turns the FP16 angle into an 8-bit index over one full turn.
        function logic [7:0] fp16_turn_index(logic [15:0] a);
            int          e;
            logic [31:0] fixed;
            logic [31:0] idx;
            e     = int'(a[14:10]) - 15;
            fixed = 32'd1024 + 32'(a[9:0]);
            if (a[14:0] == 15'd0 || e < -10)
                return 8'd0;
            if (e >= 0)
                fixed = fixed << e;
            else
                fixed = fixed >> (-e);
            // The product wraps at 32 bits for the top exponent; only bits 17:10 are kept, so the index is unaffected.
            idx = (fixed * 32'd41) >> 10;
            if (a[15])
                idx = 32'd256 - (idx & 32'hFF);
            return idx[7:0];
        endfunction

        function logic [15:0] predict(logic [15:0] a, logic k);
            logic [7:0]  idx;
            logic [15:0] flip;
            int          pos;
            idx  = fp16_turn_index(a);
            flip = 16'd0;
            if (k)
                idx = idx + 8'(fscl_pkg::TABLE_STEPS);
            case (idx[7:6])
                fscl_pkg::QUAD_RISE:  pos = int'(idx);
                fscl_pkg::QUAD_FALL:  pos = 2 * fscl_pkg::TABLE_STEPS - int'(idx);
                fscl_pkg::QUAD_NRISE:
                begin
                    pos  = int'(idx) - 2 * fscl_pkg::TABLE_STEPS;
                    flip = fscl_pkg::SIGN_FLIP;
                end
                default:
                begin
                    pos  = 4 * fscl_pkg::TABLE_STEPS - int'(idx);
                    flip = fscl_pkg::SIGN_FLIP;
                end
            endcase
            if (pos > fscl_pkg::TABLE_STEPS)
                pos = fscl_pkg::TABLE_STEPS;
            return sine_rom[pos] ^ flip;
        endfunction

        function int pending();
            return waiting.size();
        endfunction

        task report_mismatch(string msg);
            $display("error: %s", msg);
            errors++;
        endtask

        // Notes an accepted input beat.
        task note_angle(logic [15:0] a, logic k);
            trig_expect_t item;
            item.angle  = a;
            item.kind   = k;
            item.result = predict(a, k);
            waiting.push_back(item);
        endtask

        // Checks an accepted output beat against the oldest prediction.
        task check_result(logic [15:0] r);
            trig_expect_t item;
            if (waiting.size() == 0)
            begin
                report_mismatch($sformatf("output beat %h with nothing expected", r));
                return;
            end
            item = waiting.pop_front();
            if (r !== item.result)
                report_mismatch($sformatf("angle %h kind %0d: result %h, expected %h",
                                          item.angle, item.kind, r, item.result));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] angle;
    logic        kind;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] result;

    trig_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  beats_sent;
    int  cycle_count = 0;
    logic hold_off;

    logic [15:0] corner_angles [12] = '{
        16'h0000, 16'h8000, 16'h0001, 16'h13FF, 16'h1400, 16'h3C00,
        16'hBC00, 16'h3E48, 16'h4248, 16'h7BFF, 16'h7C00, 16'hFFFF
    };

    fp16_sine_cosine_lookup_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .angle     (angle),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("fp16_sine_cosine_lookup_top: mismatch");
            $finish;
        end
    end

    // Beat monitor on both channels, sampled at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_angle(angle, kind);
            if (out_valid && !out_stall)
                sb.check_result(result);
        end
    end

    // Output stall: random per phase, forced high during the long hold.
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Long output hold once the sender runs without gaps, so the pipe fills.
    initial
    begin
        hold_off <= 1'b0;
        wait (beats_sent >= 420);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offers one input beat after a random gap and waits until it is taken.
    task send_angle(logic [15:0] a, logic k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        angle    <= a;
        kind     <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // Random angle, weighted toward exponents that reach every table index.
    function automatic logic [15:0] random_angle();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return {1'($urandom), 5'($urandom_range(20, 5)), 10'($urandom)};
        else if (pick < 85)
            return 16'($urandom);
        else if (pick < 93)
            return {1'($urandom), 5'h1F, 10'($urandom)};
        else
            return {1'($urandom), 5'($urandom_range(4, 0)), 10'($urandom)};
    endfunction

    initial
    begin
        sb            = new();
        beats_sent    = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        angle         <= 16'd0;
        kind          <= 1'b0;
        send_idle_pct <= 27;
        recv_idle_pct <= 76;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner angles with both kinds.
        foreach (corner_angles[i])
        begin
            send_angle(corner_angles[i], 1'b0);
            send_angle(corner_angles[i], 1'b1);
        end

        // Random beats in three idling phases.
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS / 3)
            begin
                send_idle_pct <= 76;
                recv_idle_pct <= 27;
            end
            else if (n == 2 * RANDOM_BEATS / 3)
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            send_angle(random_angle(), 1'($urandom));
        end
        in_valid <= 1'b0;

        // Drain, then wait for stray beats.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("fp16_sine_cosine_lookup_top: match");
        else
            $display("fp16_sine_cosine_lookup_top: mismatch");
        $finish;
    end
endmodule
